/* rtl/core/xeu_pkg.sv */
// ----------------------------------------------------------------------------
// XML entity unescape package
// Shared types, keyword tables and helper functions for the entity decoder.
// ----------------------------------------------------------------------------
package xeu_pkg;

  localparam int NUM_ENT     = 7;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ENTITY,
    PH_OPENER,
    PH_CDATA
  } phase_t;

  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_AMP,
    LEAD_LT
  } lead_t;

  // One decoded item: a literal flush, held brackets, one character and a
  // closing flush, in that order of output.
  typedef struct packed {
    lead_t       a_kind;
    logic [2:0]  a_len;
    logic [2:0]  a_ent;
    logic [1:0]  nbrk;
    logic        mid_v;
    lead_t       b_kind;
    logic [2:0]  b_len;
    logic [2:0]  b_ent;
    logic        last;
    logic        unclosed;
  } cmd_t;

  function automatic logic [2:0] ent_len(input logic [2:0] ent);
    case (ent)
      3'd0: return 3'd4;
      3'd1: return 3'd5;
      3'd2: return 3'd5;
      3'd3: return 3'd3;
      3'd4: return 3'd3;
      3'd5: return 3'd4;
      3'd6: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] ent_val(input logic [2:0] ent);
    case (ent)
      3'd0: return "&";
      3'd1: return "\"";
      3'd2: return "'";
      3'd3: return ">";
      3'd4: return "<";
      3'd5: return 8'h0A;
      3'd6: return 8'h0D;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ent_kw(input logic [2:0] ent, input logic [2:0] idx);
    logic [39:0] kw;
    case (ent)
      3'd0: kw = {8'h00, ";", "p", "m", "a"};
      3'd1: kw = {";", "t", "o", "u", "q"};
      3'd2: kw = {";", "s", "o", "p", "a"};
      3'd3: kw = {8'h00, 8'h00, ";", "t", "g"};
      3'd4: kw = {8'h00, 8'h00, ";", "t", "l"};
      3'd5: kw = {8'h00, ";", "A", "x", "#"};
      3'd6: kw = {8'h00, ";", "D", "x", "#"};
      default: kw = '0;
    endcase
    case (idx)
      3'd0: return kw[7:0];
      3'd1: return kw[15:8];
      3'd2: return kw[23:16];
      3'd3: return kw[31:24];
      3'd4: return kw[39:32];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] opener(input logic [2:0] idx);
    case (idx)
      3'd0: return "!";
      3'd1: return "[";
      3'd2: return "C";
      3'd3: return "D";
      3'd4: return "A";
      3'd5: return "T";
      3'd6: return "A";
      3'd7: return "[";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [3:0] seg_len(input lead_t kind, input logic [2:0] len);
    if (kind == LEAD_NONE) begin
      return 4'd0;
    end
    return {1'b0, len} + 4'd1;
  endfunction

  function automatic logic [7:0] lead_char(input lead_t kind, input logic [3:0] k,
                                           input logic [2:0] ent);
    logic [2:0] idx;
    idx = 3'(k - 4'd1);
    if (k == 4'd0) begin
      return (kind == LEAD_AMP) ? 8'h26 : 8'h3C;
    end
    if (kind == LEAD_AMP) begin
      return ent_kw(ent, idx);
    end
    return opener(idx);
  endfunction

endpackage

/* rtl/core/xeu_front.sv */
// ----------------------------------------------------------------------------
// XML entity unescape front end
// Tracks the match state and turns each input item into at most one command.
// ----------------------------------------------------------------------------
module xeu_front #(
  parameter int CHAR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  allow_cdata,
  input  logic                  take,
  input  logic [CHAR_BITS-1:0]  in_char,
  input  logic                  in_last,
  output logic                  push,
  output xeu_pkg::cmd_t         cmd,
  output logic [CHAR_BITS-1:0]  mid_char
);
  import xeu_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         ml_r, ml_nxt;
  logic [NUM_ENT-1:0] cand_r, cand_nxt;
  logic [1:0]         pend_r, pend_nxt;
  phase_t             ph_p;
  logic [2:0]         ml_p;
  logic [NUM_ENT-1:0] cand_p;
  logic [1:0]         pend_p;
  logic [NUM_ENT-1:0] alive;
  logic               done_any;
  logic [2:0]         done_idx;
  logic [2:0]         first_cur;
  logic [2:0]         first_nxt;
  logic               do_plain;
  logic               is_amp, is_lt, is_rb, is_gt;

  assign is_amp = (in_char == CHAR_BITS'(8'h26));
  assign is_lt  = (in_char == CHAR_BITS'(8'h3C));
  assign is_rb  = (in_char == CHAR_BITS'(8'h5D));
  assign is_gt  = (in_char == CHAR_BITS'(8'h3E));

  always_comb begin
    alive     = '0;
    done_any  = 1'b0;
    done_idx  = '0;
    first_cur = '0;
    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      alive[k] = cand_r[k] && (ml_r < ent_len(3'(k))) &&
                 (in_char == CHAR_BITS'(ent_kw(3'(k), ml_r)));
      if (cand_r[k]) begin
        first_cur = 3'(k);
      end
    end
    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      if (alive[k] && (ent_len(3'(k)) == ml_r + 3'd1)) begin
        done_any = 1'b1;
        done_idx = 3'(k);
      end
    end
  end

  always_comb begin
    cmd      = '0;
    mid_char = '0;
    ph_p     = phase_r;
    ml_p     = ml_r;
    cand_p   = cand_r;
    pend_p   = pend_r;
    do_plain = 1'b0;
    first_nxt = '0;
    case (phase_r)
      PH_ENTITY: begin
        if (alive == '0) begin
          cmd.a_kind = LEAD_AMP;
          cmd.a_len  = ml_r;
          cmd.a_ent  = first_cur;
          do_plain   = 1'b1;
        end else if (done_any) begin
          cmd.mid_v = 1'b1;
          mid_char  = CHAR_BITS'(ent_val(done_idx));
          ph_p      = PH_TEXT;
          ml_p      = '0;
          cand_p    = '0;
        end else begin
          ml_p   = ml_r + 3'd1;
          cand_p = alive;
        end
      end
      PH_OPENER: begin
        if (in_char == CHAR_BITS'(opener(ml_r))) begin
          if (ml_r == 3'd7) begin
            ph_p   = PH_CDATA;
            ml_p   = '0;
            pend_p = '0;
          end else begin
            ml_p = ml_r + 3'd1;
          end
        end else begin
          cmd.a_kind = LEAD_LT;
          cmd.a_len  = ml_r;
          do_plain   = 1'b1;
        end
      end
      PH_CDATA: begin
        if (is_rb) begin
          if (pend_r == 2'd2) begin
            cmd.mid_v = 1'b1;
            mid_char  = in_char;
          end else begin
            pend_p = pend_r + 2'd1;
          end
        end else if (is_gt && pend_r == 2'd2) begin
          ph_p   = PH_TEXT;
          pend_p = '0;
        end else begin
          cmd.nbrk  = pend_r;
          pend_p    = '0;
          cmd.mid_v = 1'b1;
          mid_char  = in_char;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      ml_p   = '0;
      cand_p = '0;
      if (is_amp) begin
        ph_p   = PH_ENTITY;
        cand_p = '1;
      end else if (is_lt && allow_cdata) begin
        ph_p = PH_OPENER;
      end else begin
        ph_p      = PH_TEXT;
        cmd.mid_v = 1'b1;
        mid_char  = in_char;
      end
    end

    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      if (cand_p[k]) begin
        first_nxt = 3'(k);
      end
    end

    phase_nxt = ph_p;
    ml_nxt    = ml_p;
    cand_nxt  = cand_p;
    pend_nxt  = pend_p;
    if (in_last) begin
      cmd.last = 1'b1;
      case (ph_p)
        PH_ENTITY: begin
          cmd.b_kind = LEAD_AMP;
          cmd.b_len  = ml_p;
          cmd.b_ent  = first_nxt;
        end
        PH_OPENER: begin
          cmd.b_kind = LEAD_LT;
          cmd.b_len  = ml_p;
        end
        PH_CDATA: begin
          cmd.nbrk     = cmd.nbrk + pend_p;
          cmd.unclosed = 1'b1;
        end
        default: begin
          cmd.b_kind = LEAD_NONE;
        end
      endcase
      phase_nxt = PH_TEXT;
      ml_nxt    = '0;
      cand_nxt  = '0;
      pend_nxt  = '0;
    end
  end

  assign push = take && (in_last || cmd.a_kind != LEAD_NONE || cmd.nbrk != 2'd0 ||
                         cmd.mid_v || cmd.b_kind != LEAD_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      ml_r    <= '0;
      cand_r  <= '0;
      pend_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      ml_r    <= ml_nxt;
      cand_r  <= cand_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

/* rtl/core/xeu_queue.sv */
// ----------------------------------------------------------------------------
// XML entity unescape command queue
// Small register FIFO between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module xeu_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             ready,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign ready     = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/xeu_back.sv */
// ----------------------------------------------------------------------------
// XML entity unescape output sequencer
// Expands each command into result items, one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module xeu_back #(
  parameter int CHAR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  xeu_pkg::cmd_t        cmd,
  input  logic [CHAR_BITS-1:0] mid_char,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [CHAR_BITS-1:0] out_char,
  output logic                 out_cv,
  output logic                 out_last,
  output logic                 out_unc
);
  import xeu_pkg::*;

  logic [3:0]           j_r, j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0] out_char_r;
  logic                 out_cv_r, out_last_r, out_unc_r;
  logic [3:0]           p1, p2, p3, n;
  logic [3:0]           final_j;
  logic [CHAR_BITS-1:0] ch;
  logic                 emit;

  always_comb begin
    p1 = seg_len(cmd.a_kind, cmd.a_len);
    p2 = p1 + {2'b00, cmd.nbrk};
    p3 = p2 + {3'b000, cmd.mid_v};
    n  = p3 + seg_len(cmd.b_kind, cmd.b_len);
    final_j = (n == 4'd0) ? 4'd0 : n - 4'd1;
    if (n == 4'd0) begin
      ch = '0;
    end else if (j_r < p1) begin
      ch = CHAR_BITS'(lead_char(cmd.a_kind, j_r, cmd.a_ent));
    end else if (j_r < p2) begin
      ch = CHAR_BITS'(8'h5D);
    end else if (j_r < p3) begin
      ch = mid_char;
    end else begin
      ch = CHAR_BITS'(lead_char(cmd.b_kind, j_r - p3, cmd.b_ent));
    end
  end

  assign emit  = q_valid && (!out_valid_r || out_tready);
  assign q_pop = emit && (j_r == final_j);

  always_comb begin
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      j_nxt         = q_pop ? 4'd0 : j_r + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= ch;
      out_cv_r   <= (n != 4'd0);
      out_last_r <= cmd.last && q_pop;
      out_unc_r  <= cmd.last && q_pop && cmd.unclosed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_cv     = out_cv_r;
  assign out_last   = out_last_r;
  assign out_unc    = out_unc_r;

  a_pop_on_emit: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> emit)
    else $error("Command retired without issuing a result.");
  a_mid_cmd: assert property (@(posedge clk) disable iff (!rst_n) (j_r != 4'd0) |-> q_valid)
    else $error("Result index advanced with no command at the head of the queue.");
  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
                                  (out_valid_r && !out_cv_r) |-> out_last_r)
    else $error("Empty result item is not the final one.");
  a_unc_final: assert property (@(posedge clk) disable iff (!rst_n)
                                (out_valid_r && out_unc_r) |-> out_last_r)
    else $error("Unclosed CDATA flag on a non-final result item.");

endmodule

/* rtl/core/xml_entity_unescape_cdata.sv */
// An input item is queued as a command; its results leave through the output register.
// Throughput: one input item per cycle, with at most one result each and no output stall.
// An item's results enter the output register one per cycle unless the output stalls.
// A four-entry command queue lets the input side run ahead of a stalled output.
// Reset (rst_n low, synchronous) clears the match state, the queue and allow_cdata.
// ----------------------------------------------------------------------------
// XML entity unescape with CDATA pass-through
// Decodes XML entities in a stream of code units and strips CDATA delimiters.
// ----------------------------------------------------------------------------
module xml_entity_unescape_cdata #(
  parameter int CHAR_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((CHAR_BITS+7)/8)*8-1:0]     in_tdata,   // in_char
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((CHAR_BITS+7)/8)*8-1:0]     out_tdata,  // out_char
  output logic [1:0]                         out_tuser,  // char_valid, unclosed_cdata
  output logic                               out_tlast
);
  import xeu_pkg::*;

  localparam int TDATA_W = ((CHAR_BITS + 7) / 8) * 8;
  localparam int CMD_W   = $bits(cmd_t);
  localparam int Q_W     = CMD_W + CHAR_BITS;

  logic                 allow_r;
  logic                 take;
  logic                 push;
  cmd_t                 f_cmd;
  logic [CHAR_BITS-1:0] f_mid;
  logic                 q_ready, q_valid, q_pop;
  logic [Q_W-1:0]       q_rd;
  cmd_t                 b_cmd;
  logic [CHAR_BITS-1:0] b_mid;
  logic [CHAR_BITS-1:0] out_char;
  logic                 out_cv, out_last, out_unc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= 1'b0;
    end else if (cfg_we) begin
      allow_r <= cfg_wdata;
    end
  end

  assign in_tready = q_ready;
  assign take      = in_tvalid && q_ready;

  xeu_front #(.CHAR_BITS(CHAR_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .allow_cdata (allow_r),
    .take        (take),
    .in_char     (in_tdata[CHAR_BITS-1:0]),
    .in_last     (in_tlast),
    .push        (push),
    .cmd         (f_cmd),
    .mid_char    (f_mid)
  );

  xeu_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   ({f_cmd, f_mid}),
    .pop       (q_pop),
    .ready     (q_ready),
    .not_empty (q_valid),
    .rd_data   (q_rd)
  );

  assign b_cmd = cmd_t'(q_rd[Q_W-1:CHAR_BITS]);
  assign b_mid = q_rd[CHAR_BITS-1:0];

  xeu_back #(.CHAR_BITS(CHAR_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .cmd        (b_cmd),
    .mid_char   (b_mid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_cv     (out_cv),
    .out_last   (out_last),
    .out_unc    (out_unc)
  );

  assign out_tdata = TDATA_W'(out_char);
  assign out_tuser = {out_unc, out_cv};
  assign out_tlast = out_last;

endmodule

/* tb/xeu_decode_checker.sv */
// ----------------------------------------------------------------------------
// XML entity unescape checker
// Watches both streams of the decoder. It predicts the decoded code units of
// each accepted input item and compares each accepted result item with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module xeu_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // in_char
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // out_char
  input  logic [1:0]  out_tuser,  // char_valid, unclosed_cdata
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          unclosed_ends
);
  import xeu_pkg::*;

  typedef struct packed {
    logic [15:0] ch;
    logic        vld;
    logic        last;
    logic        unclosed;
  } unit_t;

  logic [7:0] ent_key [0:6][0:4] = '{
    '{"a", "m", "p", ";", 8'h00},
    '{"q", "u", "o", "t", ";"},
    '{"a", "p", "o", "s", ";"},
    '{"g", "t", ";", 8'h00, 8'h00},
    '{"l", "t", ";", 8'h00, 8'h00},
    '{"#", "x", "A", ";", 8'h00},
    '{"#", "x", "D", ";", 8'h00}
  };
  int         ent_size [0:6] = '{4, 5, 5, 3, 3, 4, 4};
  logic [7:0] ent_char [0:6] = '{"&", "\"", "'", ">", "<", 8'h0A, 8'h0D};
  logic [7:0] cdata_key [0:7] = '{"!", "[", "C", "D", "A", "T", "A", "["};

  unit_t      decoded_q[$];
  phase_t     ph;
  int         mlen;
  logic [6:0] cands;
  int         held;
  logic       cdata_en;
  int         step_n;
  int         errs;
  int         n_checked;
  int         n_unclosed;

  function automatic void put_char(input logic [15:0] c);
    unit_t u;
    u.ch       = c;
    u.vld      = 1'b1;
    u.last     = 1'b0;
    u.unclosed = 1'b0;
    decoded_q.insert(decoded_q.size(), u);
    step_n++;
  endfunction

  function automatic void flush_amp();
    put_char(16'h0026);
    for (int k = 0; k < 7; k++) begin
      if (cands[k]) begin
        for (int i = 0; i < mlen && i < ent_size[k]; i++) begin
          put_char({8'h00, ent_key[k][i]});
        end
        break;
      end
    end
  endfunction

  function automatic void flush_lt();
    put_char(16'h003C);
    for (int i = 0; i < mlen && i < 8; i++) begin
      put_char({8'h00, cdata_key[i]});
    end
  endfunction

  function automatic void release_brackets();
    while (held > 0) begin
      put_char(16'h005D);
      held--;
    end
  endfunction

  function automatic void plain_unit(input logic [15:0] c);
    mlen  = 0;
    cands = '0;
    if (c == 16'h0026) begin
      ph    = PH_ENTITY;
      cands = 7'h7F;
    end else if (c == 16'h003C && cdata_en) begin
      ph = PH_OPENER;
    end else begin
      ph = PH_TEXT;
      put_char(c);
    end
  endfunction

  function automatic void step_unit(input logic [15:0] c);
    logic [6:0] alive;
    alive = '0;
    case (ph)
      PH_ENTITY: begin
        for (int k = 0; k < 7; k++) begin
          if (cands[k] && mlen < ent_size[k] && c == {8'h00, ent_key[k][mlen]}) begin
            alive[k] = 1'b1;
          end
        end
        if (alive == '0) begin
          flush_amp();
          plain_unit(c);
          return;
        end
        mlen++;
        cands = alive;
        for (int k = 0; k < 7; k++) begin
          if (alive[k] && ent_size[k] == mlen) begin
            put_char({8'h00, ent_char[k]});
            ph    = PH_TEXT;
            mlen  = 0;
            cands = '0;
            return;
          end
        end
      end
      PH_OPENER: begin
        if (mlen < 8 && c == {8'h00, cdata_key[mlen]}) begin
          mlen++;
          if (mlen == 8) begin
            ph   = PH_CDATA;
            mlen = 0;
            held = 0;
          end
        end else begin
          flush_lt();
          plain_unit(c);
        end
      end
      PH_CDATA: begin
        if (c == 16'h005D) begin
          if (held >= 2) begin
            put_char(c);
          end else begin
            held++;
          end
        end else if (c == 16'h003E && held >= 2) begin
          ph   = PH_TEXT;
          held = 0;
        end else begin
          release_brackets();
          put_char(c);
        end
      end
      default: begin
        plain_unit(c);
      end
    endcase
  endfunction

  function automatic void decode_unit(input logic [15:0] c, input logic last);
    logic  ends_open;
    unit_t tail;
    ends_open = 1'b0;
    step_n    = 0;
    step_unit(c);
    if (last) begin
      case (ph)
        PH_ENTITY: begin
          flush_amp();
        end
        PH_OPENER: begin
          flush_lt();
        end
        PH_CDATA: begin
          release_brackets();
          ends_open = 1'b1;
        end
        default: begin
        end
      endcase
      if (step_n == 0) begin
        tail = '0;
      end else begin
        tail = decoded_q.pop_back();
      end
      tail.last     = 1'b1;
      tail.unclosed = ends_open;
      decoded_q.insert(decoded_q.size(), tail);
      ph    = PH_TEXT;
      mlen  = 0;
      cands = '0;
      held  = 0;
    end
  endfunction

  always @(posedge clk) begin : watch_streams
    unit_t want;
    if (!rst_n) begin
      ph       = PH_TEXT;
      mlen     = 0;
      cands    = '0;
      held     = 0;
      cdata_en = 1'b0;
      decoded_q.delete();
    end else begin
      if (cfg_we) begin
        cdata_en = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        decode_unit(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (decoded_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("ERROR: unexpected result item: char %h valid %b last %b unclosed %b",
                     out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
          end
        end else begin
          want = decoded_q.pop_front();
          if (want.unclosed) begin
            n_unclosed++;
          end
          if (out_tdata !== want.ch || out_tuser[0] !== want.vld ||
              out_tlast !== want.last || out_tuser[1] !== want.unclosed) begin
            errs++;
            if (errs <= 10) begin
              $display("ERROR: result item %0d: expected char %h valid %b last %b unclosed %b",
                       n_checked, want.ch, want.vld, want.last, want.unclosed);
              $display("       got char %h valid %b last %b unclosed %b",
                       out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
            end
          end
        end
      end
    end
    fail_count    <= errs;
    pending       <= decoded_q.size();
    checked       <= n_checked;
    unclosed_ends <= n_unclosed;
  end

endmodule

/* tb/tb_xml_entity_unescape_cdata.sv */
// ----------------------------------------------------------------------------
// XML entity unescape testbench
// Drives strings of code units through the decoder: a few directed strings,
// then random strings built from whole and broken entities, CDATA sections
// and plain text, under several mixes of idle input and stalled output, with
// CDATA handling off and on. A checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_xml_entity_unescape_cdata;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // in_char
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // out_char
  logic [1:0]  out_tuser;         // char_valid, unclosed_cdata
  logic        out_tlast;
  logic        hold_req   = 1'b0;

  int          send_idle  = 0;
  int          recv_stall = 0;
  int          fail_count;
  int          pending;
  int          checked;
  int          unclosed_ends;
  int          items_sent   = 0;
  int          strings_sent = 0;
  logic [15:0] text_q[$];
  string       ent_name [0:6] = '{"amp;", "quot;", "apos;", "gt;", "lt;", "#xA;", "#xD;"};
  string       cdata_open = "<![CDATA[";
  int          idle_mix  [0:3] = '{0, 77, 0, 19};
  int          stall_mix [0:3] = '{0, 0, 77, 19};

  xml_entity_unescape_cdata #(
    .CHAR_BITS(16)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  xeu_decode_checker decode_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .unclosed_ends(unclosed_ends)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A requested hold-off keeps the output stalled for a long stretch.
  always @(posedge clk) begin : receiver
    int hold_left;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_req   <= 1'b0;
      hold_left  = 80;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_unit(input logic [15:0] c, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_unit(text_q[i], i == text_q.size() - 1);
    end
    strings_sent++;
    text_q.delete();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cdata(input logic en);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void push_unit(input logic [15:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.insert(text_q.size(), {8'h00, s[i]});
    end
  endfunction

  function automatic logic [15:0] text_unit();
    int    r;
    string marks;
    marks = "&<>];#x!";
    r = $urandom_range(99);
    if (r < 50) begin
      return 16'($urandom_range(126, 32));
    end
    if (r < 75) begin
      return {8'h00, marks[$urandom_range(marks.len() - 1)]};
    end
    if (r < 90) begin
      return 16'($urandom_range(65535));
    end
    // Keyword characters with a high byte set must not match.
    return {8'($urandom_range(255, 1)), marks[$urandom_range(marks.len() - 1)]};
  endfunction

  function automatic logic [15:0] cdata_unit();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      return 16'h005D;
    end
    if (r < 55) begin
      return 16'h003E;
    end
    return text_unit();
  endfunction

  function automatic void add_token();
    int    r;
    int    n;
    string key;
    r = $urandom_range(99);
    if (r < 25) begin
      push_unit(16'h0026);
      push_str(ent_name[$urandom_range(6)]);
    end else if (r < 35) begin
      key = ent_name[$urandom_range(6)];
      n = $urandom_range(key.len() - 1);
      push_unit(16'h0026);
      for (int i = 0; i < n; i++) begin
        push_unit({8'h00, key[i]});
      end
      push_unit(text_unit());
    end else if (r < 55) begin
      push_unit(text_unit());
    end else if (r < 80) begin
      push_str(cdata_open);
      n = $urandom_range(5);
      repeat (n) push_unit(cdata_unit());
      r = $urandom_range(9);
      if (r < 6) begin
        push_str("]]>");
      end else if (r < 8) begin
        push_str("]]]>");
      end
    end else if (r < 92) begin
      n = $urandom_range(7);
      push_unit(16'h003C);
      for (int i = 0; i < n; i++) begin
        push_unit({8'h00, cdata_open[i + 1]});
      end
      push_unit(text_unit());
    end else begin
      push_unit(16'h0026);
    end
  endfunction

  function automatic void make_text();
    int cut;
    repeat ($urandom_range(5, 1)) add_token();
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(text_q.size(), 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
  endfunction

  initial begin : stimulus
    int goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: extreme code units, a broken entity, a string ending
    // inside an entity, '<' as plain text, and a CDATA section with an extra
    // bracket closing on the last item, which leaves an empty final result.
    set_cdata(1'b0);
    push_unit(16'h0000);
    push_unit(16'hFFFF);
    push_str("&ax");
    send_text();
    push_str("&#xD");
    send_text();
    push_str("&lt;<");
    send_text();
    set_cdata(1'b1);
    push_str("<![CDATA[]]]>");
    send_text();

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        set_cdata(s == 0 ? p[0] : !p[0]);
        send_idle  = idle_mix[p];
        recv_stall = stall_mix[p];
        if (p == 0 && s == 0) begin
          hold_req <= 1'b1;
        end
        goal = items_sent + 32;
        while (items_sent < goal) begin
          make_text();
          send_text();
        end
      end
    end

    settle();
    repeat (6) @(posedge clk);
    $display("Sent %0d items in %0d strings under four idle and stall mixes, CDATA off and on;",
             items_sent, strings_sent);
    $display("checked %0d result items, %0d of them ending a string inside CDATA.",
             checked, unclosed_ends);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_xml_entity_unescape_cdata OK");
    end else begin
      $display("tb_xml_entity_unescape_cdata NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("tb_xml_entity_unescape_cdata NOT OK");
    $finish;
  end

endmodule

/* xml_entity_unescape_cdata.f */
rtl/core/xeu_pkg.sv
rtl/core/xeu_front.sv
rtl/core/xeu_queue.sv
rtl/core/xeu_back.sv
rtl/core/xml_entity_unescape_cdata.sv
tb/xeu_decode_checker.sv
tb/tb_xml_entity_unescape_cdata.sv
